/* rtl/core/wti_pkg.sv */
package wti_pkg;

    localparam int TABLE_BITS  = 9;
    localparam int PHASE_BITS  = 32;
    localparam int FRAC_BITS   = PHASE_BITS - TABLE_BITS;
    localparam int SCALE_POINT = 28;

    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = 10;
    localparam int FREQ_W    = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_W     = FREQ_W + CFG_W + 1;

    localparam int TABLE_LEN  = (1 << TABLE_BITS) + 1;
    localparam int EVEN_DEPTH = (1 << (TABLE_BITS - 1)) + 1;
    localparam int ODD_DEPTH  = 1 << (TABLE_BITS - 1);

    // (b - a) * frac: 17-bit signed difference times unsigned fraction
    localparam int PROD_W = SAMPLE_W + 1 + FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SOURCE     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SCALE     = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_sample           value;
    } t_tbl_wr;

    typedef struct packed {
        logic                  en;
        logic [TABLE_BITS-1:0] index;
    } t_tbl_rd;

endpackage

/* rtl/core/wavetable_oscillator_interp.sv */
// Wavetable oscillator with linear interpolation. A 32-bit phase
// accumulator walks a 513-entry Q1.15 table (512 points plus a guard point
// at the end, which the user writes as a copy of entry 0 for a periodic
// wave). Each item carries an action: a tick gives one Q1.15 sample, the
// entry picked by the top 9 phase bits blended toward its successor by the
// lower 23 bits, and then advances the phase by either the phase_increment
// register or frequency_sample (Q16.16) times phase_scale (Q20.12); a write
// loads one table entry (addresses above 512 are dropped); a clear zeroes
// the phase; action 3 does nothing. Only ticks give a beat on the output.
// The block takes one item every cycle unless a stalled output backs up
// the pipeline. A tick's sample is registered in order: the frequency
// multiply with the beat as it is accepted, then the table read, the
// interpolation multiply and the rounding add into the output register.
// The phase add and all table writes happen in the same cycle as the
// read, so later ticks always see earlier writes. The table has no reset;
// reading an entry never written gives an unspecified sample.
// The user must write registers through the configuration port only
// while the block is idle; the block itself does not enforce this. Its
// ready is always high.
module wavetable_oscillator_interp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_action,
    input  logic [wti_pkg::ADDR_W-1:0]      i_table_address,
    input  logic signed [wti_pkg::SAMPLE_W-1:0] i_table_value,
    input  logic signed [wti_pkg::FREQ_W-1:0]   i_frequency_sample,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic signed [wti_pkg::SAMPLE_W-1:0] o_sample,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wti_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wti_pkg::CFG_W-1:0]       i_cfg_data
);

    // Configuration registers
    logic                             r_freq_source;
    logic [wti_pkg::PHASE_BITS-1:0]   r_phase_increment;
    logic [wti_pkg::CFG_W-1:0]        r_phase_scale;

    // Stage 1: decoded item and its phase step
    logic                             r_v1;
    wti_pkg::t_action                 r_act1;
    logic [wti_pkg::ADDR_W-1:0]       r_addr1;
    wti_pkg::t_sample                 r_val1;
    logic [wti_pkg::PHASE_BITS-1:0]   r_step1;

    logic [wti_pkg::PHASE_BITS-1:0]   r_phase;

    logic                             w_accept;
    logic                             w_tick1;
    logic                             w_adv1;
    logic                             w_ready2;
    logic signed [wti_pkg::MUL_W-1:0] w_mul;
    logic [wti_pkg::PHASE_BITS-1:0]   n_step;
    wti_pkg::t_tbl_wr                 w_wr;
    wti_pkg::t_tbl_rd                 w_rd;
    wti_pkg::t_sample                 w_a;
    wti_pkg::t_sample                 w_b;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_source     <= 1'b0;
            r_phase_increment <= '0;
            r_phase_scale     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wti_pkg::CFG_FREQ_SOURCE: begin
                    r_freq_source <= i_cfg_data[0];
                end
                wti_pkg::CFG_PHASE_INCREMENT: begin
                    r_phase_increment <= i_cfg_data[wti_pkg::PHASE_BITS-1:0];
                end
                wti_pkg::CFG_PHASE_SCALE: begin
                    r_phase_scale <= i_cfg_data;
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Signed frequency times unsigned scale is Q36.28; keep the integer
    // part modulo the phase range.
    assign w_mul  = i_frequency_sample * $signed({1'b0, r_phase_scale});
    assign n_step = r_freq_source ? w_mul[wti_pkg::SCALE_POINT +: wti_pkg::PHASE_BITS]
                                  : r_phase_increment;

    // Non-tick items retire out of stage 1; ticks wait for the read stage.
    assign w_tick1  = r_v1 && (r_act1 == wti_pkg::ACT_TICK);
    assign w_adv1   = r_v1 && (!w_tick1 || w_ready2);
    assign o_stall  = r_v1 && !w_adv1;
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_accept) begin
            r_v1 <= 1'b1;
        end else if (w_adv1) begin
            r_v1 <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act1  <= wti_pkg::t_action'(i_action);
            r_addr1 <= i_table_address;
            r_val1  <= i_table_value;
            r_step1 <= n_step;
        end
    end

    // Advance or clear the phase as the item leaves stage 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (w_adv1) begin
            case (r_act1)
                wti_pkg::ACT_TICK: begin
                    r_phase <= r_phase + r_step1;
                end
                wti_pkg::ACT_CLEAR: begin
                    r_phase <= '0;
                end
                default: begin
                    // hold
                end
            endcase
        end
    end

    always_comb begin
        w_wr.en    = r_v1 && (r_act1 == wti_pkg::ACT_WRITE)
                     && (r_addr1 < wti_pkg::ADDR_W'(wti_pkg::TABLE_LEN));
        w_wr.addr  = r_addr1;
        w_wr.value = r_val1;
        w_rd.en    = w_tick1 && w_ready2;
        w_rd.index = r_phase[wti_pkg::PHASE_BITS-1 -: wti_pkg::TABLE_BITS];
    end

    wti_table u_table (
        .i_clk (i_clk),
        .i_wr  (w_wr),
        .i_rd  (w_rd),
        .o_a   (w_a),
        .o_b   (w_b)
    );

    wti_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_rd.en),
        .i_frac   (r_phase[wti_pkg::FRAC_BITS-1:0]),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_ready  (w_ready2),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_sample (o_sample)
    );

endmodule

/* rtl/core/wti_table.sv */
module wti_table (
    input  logic             i_clk,
    input  wti_pkg::t_tbl_wr i_wr,
    input  wti_pkg::t_tbl_rd i_rd,
    output wti_pkg::t_sample o_a,
    output wti_pkg::t_sample o_b
);

    // Even entries (guard point included) and odd entries live in separate
    // banks, so an entry and its successor are always read together.
    wti_pkg::t_sample r_even [wti_pkg::EVEN_DEPTH];
    wti_pkg::t_sample r_odd_bank [wti_pkg::ODD_DEPTH];

    wti_pkg::t_sample r_even_q;
    wti_pkg::t_sample r_odd_q;
    logic             r_odd_sel;

    logic [wti_pkg::TABLE_BITS-2:0] w_half;
    logic [wti_pkg::TABLE_BITS-1:0] w_even_raddr;
    logic                           w_wr_even;
    logic                           w_wr_odd;

    assign w_half       = i_rd.index[wti_pkg::TABLE_BITS-1:1];
    assign w_even_raddr = {1'b0, w_half} + wti_pkg::TABLE_BITS'(i_rd.index[0]);

    assign w_wr_even = i_wr.en && !i_wr.addr[0];
    assign w_wr_odd  = i_wr.en &&  i_wr.addr[0];

    always_ff @(posedge i_clk) begin
        if (w_wr_even) begin
            r_even[i_wr.addr[wti_pkg::TABLE_BITS:1]] <= i_wr.value;
        end
        if (i_rd.en) begin
            r_even_q <= r_even[w_even_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_odd) begin
            r_odd_bank[i_wr.addr[wti_pkg::TABLE_BITS-1:1]] <= i_wr.value;
        end
        if (i_rd.en) begin
            r_odd_q   <= r_odd_bank[w_half];
            r_odd_sel <= i_rd.index[0];
        end
    end

    assign o_a = r_odd_sel ? r_odd_q  : r_even_q;
    assign o_b = r_odd_sel ? r_even_q : r_odd_q;

endmodule

/* rtl/core/wti_interp.sv */
module wti_interp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [wti_pkg::FRAC_BITS-1:0] i_frac,
    input  wti_pkg::t_sample              i_a,
    input  wti_pkg::t_sample              i_b,
    output logic                          o_ready,
    input  logic                          i_stall,
    output logic                          o_valid,
    output wti_pkg::t_sample              o_sample
);

    localparam logic signed [wti_pkg::PROD_W-1:0] ROUND =
        {{(wti_pkg::PROD_W - wti_pkg::FRAC_BITS){1'b0}}, 1'b1,
         {(wti_pkg::FRAC_BITS - 1){1'b0}}};

    logic                          r_v2;
    logic [wti_pkg::FRAC_BITS-1:0] r_frac2;
    logic                          r_v3;
    logic signed [wti_pkg::PROD_W-1:0] r_prod3;
    wti_pkg::t_sample              r_a3;
    logic                          r_v4;
    wti_pkg::t_sample              r_sample;

    logic                              w_rdy4;
    logic                              w_rdy3;
    logic                              w_adv3;
    logic                              w_adv2;
    logic signed [wti_pkg::SAMPLE_W:0] w_diff;
    logic signed [wti_pkg::PROD_W-1:0] w_prod;
    logic signed [wti_pkg::PROD_W-1:0] w_rnd;
    logic signed [wti_pkg::PROD_W-1:0] w_shift;
    logic signed [wti_pkg::SAMPLE_W:0] w_sum;

    assign w_rdy4  = !r_v4 || !i_stall;
    assign w_adv3  = r_v3 && w_rdy4;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_adv2  = r_v2 && w_rdy3;
    assign o_ready = !r_v2 || w_rdy3;

    assign w_diff = {i_b[wti_pkg::SAMPLE_W-1], i_b} - {i_a[wti_pkg::SAMPLE_W-1], i_a};
    assign w_prod = w_diff * $signed({1'b0, r_frac2});

    assign w_rnd   = r_prod3 + ROUND;
    assign w_shift = w_rnd >>> wti_pkg::FRAC_BITS;
    assign w_sum   = {r_a3[wti_pkg::SAMPLE_W-1], r_a3} + w_shift[wti_pkg::SAMPLE_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (i_load) begin
                r_v2 <= 1'b1;
            end else if (w_adv2) begin
                r_v2 <= 1'b0;
            end
            if (w_adv2) begin
                r_v3 <= 1'b1;
            end else if (w_adv3) begin
                r_v3 <= 1'b0;
            end
            if (w_adv3) begin
                r_v4 <= 1'b1;
            end else if (w_rdy4) begin
                r_v4 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frac2 <= i_frac;
        end
        if (w_adv2) begin
            r_prod3 <= w_prod;
            r_a3    <= i_a;
        end
        if (w_adv3) begin
            r_sample <= w_sum[wti_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_valid  = r_v4;
    assign o_sample = r_sample;

endmodule

/* rtl/core/wti_check.sv */
module wti_check (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [wti_pkg::SAMPLE_W-1:0] o_sample,
    input logic                        o_cfg_ready
);

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat present after reset");

    // With nothing waiting at the output every stage can move, so no stall.
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("stalled output beat changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind wavetable_oscillator_interp wti_check u_wti_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_sample    (o_sample),
    .o_cfg_ready (o_cfg_ready)
);

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import wti_pkg::*;

    // Action code with no effect; the package only names the three real ones.
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT   = 1000;
    localparam int PHASE_COUNT      = 7;
    localparam int BEATS_PER_PHASE  = 110;

    // Q20.12 scale of 2^28 makes the signal-mode step equal frequency_sample.
    localparam logic [CFG_W-1:0] UNIT_SCALE = 32'h1000_0000;

    localparam t_sample Q15_MAX = 16'sh7FFF;
    localparam t_sample Q15_MIN = 16'sh8000;
    localparam logic signed [FREQ_W-1:0] HALF_ENTRY = 32'sh0040_0000;
    localparam logic signed [FREQ_W-1:0] ONE_ENTRY  = 32'sh0080_0000;

    // One input beat plus, for directed rows, a sample typed in by hand.
    typedef struct packed {
        logic [1:0]                 action;
        logic [ADDR_W-1:0]          address;
        t_sample                    value;
        logic signed [FREQ_W-1:0]   frequency;
        logic                       pinned;
        t_sample                    pinned_sample;
    } osc_beat_t;

    // Directed rows, run in signal mode with UNIT_SCALE so that each tick's
    // frequency is the phase step itself. The table is fully loaded first.
    localparam osc_beat_t DIRECTED_BEATS [21] = '{
        '{ACT_WRITE, 10'd0,    Q15_MAX,     32'sd0,       1'b0, 16'sd0},
        '{ACT_WRITE, 10'd1,    Q15_MIN,     32'sd0,       1'b0, 16'sd0},
        // first tick after reset reads entry 0 exactly
        '{ACT_TICK,  10'd0,    16'sd0,      HALF_ENTRY,   1'b1, Q15_MAX},
        // halfway down the full-scale step rounds to zero
        '{ACT_TICK,  10'd0,    16'sd0,      32'sd0,       1'b1, 16'sd0},
        '{ACT_CLEAR, 10'd0,    16'sd0,      32'sd0,       1'b0, 16'sd0},
        // unused action: must leave the phase and table alone
        '{ACT_NONE,  10'd0,    Q15_MIN,     ONE_ENTRY,    1'b0, 16'sd0},
        // negative frequency runs backward into the last entry
        '{ACT_TICK,  10'd0,    16'sd0,      -ONE_ENTRY,   1'b1, Q15_MAX},
        '{ACT_WRITE, 10'd511,  Q15_MAX,     32'sd0,       1'b0, 16'sd0},
        '{ACT_WRITE, 10'd512,  Q15_MIN,     32'sd0,       1'b0, 16'sd0},
        // addresses past the guard point are dropped
        '{ACT_WRITE, 10'd513,  16'sd1234,   32'sd0,       1'b0, 16'sd0},
        '{ACT_WRITE, 10'd1023, -16'sd1,     32'sd0,       1'b0, 16'sd0},
        '{ACT_TICK,  10'd0,    16'sd0,      HALF_ENTRY,   1'b1, Q15_MAX},
        // interpolate into the guard point, then wrap to zero
        '{ACT_TICK,  10'd0,    16'sd0,      HALF_ENTRY,   1'b1, 16'sd0},
        '{ACT_TICK,  10'd0,    16'sd0,      32'sh8000_0000, 1'b1, Q15_MAX},
        '{ACT_TICK,  10'd0,    16'sd0,      32'sh7FFF_FFFF, 1'b0, 16'sd0},
        // largest fraction on a falling full-scale step
        '{ACT_TICK,  10'd0,    16'sd0,      32'sd1,       1'b0, 16'sd0},
        '{ACT_WRITE, 10'd0,    Q15_MIN,     32'sd0,       1'b0, 16'sd0},
        '{ACT_WRITE, 10'd1,    Q15_MAX,     32'sd0,       1'b0, 16'sd0},
        '{ACT_TICK,  10'd0,    16'sd0,      ONE_ENTRY - 1, 1'b1, Q15_MIN},
        // largest fraction on a rising full-scale step
        '{ACT_TICK,  10'd0,    16'sd0,      32'sd1,       1'b0, 16'sd0},
        '{ACT_TICK,  10'd0,    16'sd0,      32'sd0,       1'b1, Q15_MAX}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic       i_valid = 1'b0;
    logic       o_stall;
    osc_beat_t  offered = '0;

    logic       o_valid;
    logic       i_stall = 1'b0;
    t_sample    o_sample;

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // Predictor state: its own copy of the registers, phase and table.
    logic                  cfg_freq_source     = 1'b0;
    logic [CFG_W-1:0]      cfg_phase_increment = '0;
    logic [CFG_W-1:0]      cfg_phase_scale     = '0;
    logic [PHASE_BITS-1:0] phase_acc           = '0;
    t_sample               wave_shadow [TABLE_LEN];

    t_sample expected_samples [$];
    t_sample wanted_sample;

    int  failures        = 0;
    int  stalled_cycles  = 0;
    bit  calm            = 1'b0;   // no idling on either side
    bit  long_hold_request = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    wavetable_oscillator_interp uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_action           (offered.action),
        .i_table_address    (offered.address),
        .i_table_value      (offered.value),
        .i_frequency_sample (offered.frequency),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_sample           (o_sample),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // Apply one accepted beat to the predictor; a tick queues its sample.
    task automatic advance_oscillator(input osc_beat_t beat);
        logic [TABLE_BITS-1:0] index;
        longint                lo;
        longint                hi;
        longint                frac;
        longint                blend;
        longint                product;
        logic [PHASE_BITS-1:0] step;
        t_sample               predicted;
        case (beat.action)
            ACT_WRITE: begin
                if (beat.address < TABLE_LEN)
                    wave_shadow[beat.address] = beat.value;
            end
            ACT_CLEAR: begin
                phase_acc = '0;
            end
            ACT_TICK: begin
                index = phase_acc[PHASE_BITS-1 -: TABLE_BITS];
                lo    = wave_shadow[index];
                hi    = wave_shadow[int'(index) + 1];
                frac  = longint'(phase_acc[FRAC_BITS-1:0]);
                // round to nearest, ties upward: add half then floor-shift
                blend = (hi - lo) * frac + (longint'(1) << (FRAC_BITS - 1));
                predicted = t_sample'(lo + (blend >>> FRAC_BITS));
                expected_samples.push_back(beat.pinned ? beat.pinned_sample : predicted);
                if (cfg_freq_source) begin
                    // signed Q16.16 times unsigned Q20.12, keep bits above Q.28
                    product = longint'(beat.frequency) * longint'(cfg_phase_scale);
                    step    = product[SCALE_POINT +: PHASE_BITS];
                end else begin
                    step = cfg_phase_increment;
                end
                phase_acc = phase_acc + step;
            end
            default: ;
        endcase
    endtask

    // Sample both handshakes at the edge; inputs move only by NBA, so every
    // read here sees the values from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                advance_oscillator(offered);

            if (o_valid && !i_stall) begin
                if (expected_samples.size() == 0) begin
                    failures++;
                    $display("%0t: sample with none expected: expected none, actual %0d",
                             $time, o_sample);
                end else begin
                    wanted_sample = expected_samples.pop_front();
                    if (o_sample !== wanted_sample) begin
                        failures++;
                        $display("%0t: sample mismatch: expected %0d, actual %0d",
                                 $time, wanted_sample, o_sample);
                    end
                end
            end

            // Watchdog: count edges where nothing moves on any channel.
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
                if (stalled_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: no progress for %0d cycles, %0d samples outstanding",
                             $time, WATCHDOG_LIMIT, expected_samples.size());
                    $display("** wavetable_oscillator_interp: FAILED **");
                    $finish;
                end
            end
        end
    end

    // Receiver: random stall bursts, one long hold on request, none when calm.
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                i_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one beat, perhaps after an idle burst, and hold it until taken.
    task automatic offer(input osc_beat_t beat);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        offered <= beat;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Drop valid, wait for every sample, then let the pipeline empty out.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Hold one register write until taken; valid stays up for the next one.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_FREQ_SOURCE:     cfg_freq_source     = data[0];
            CFG_PHASE_INCREMENT: cfg_phase_increment = data;
            CFG_PHASE_SCALE:     cfg_phase_scale     = data;
            default: ;
        endcase
    endtask

    task automatic program_oscillator(input logic source, input logic [CFG_W-1:0] increment,
                                      input logic [CFG_W-1:0] scale);
        // junk in the upper bits of the mode word must be ignored
        write_cfg(CFG_FREQ_SOURCE, {31'($urandom), source});
        write_cfg(CFG_PHASE_INCREMENT, increment);
        write_cfg(CFG_PHASE_SCALE, scale);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly ticks; writes stay inside the table apart from a few dropped ones.
    function automatic osc_beat_t random_beat();
        osc_beat_t beat;
        int        pick;
        pick           = $urandom_range(0, 99);
        beat           = '0;
        beat.value     = t_sample'($urandom);
        beat.frequency = FREQ_W'($urandom);
        beat.address   = ADDR_W'($urandom);
        if (pick < 70) begin
            beat.action = ACT_TICK;
        end else if (pick < 85) begin
            beat.action = ACT_WRITE;
            if ($urandom_range(0, 9) == 0)
                beat.address = ADDR_W'($urandom_range(TABLE_LEN, (1 << ADDR_W) - 1));
            else
                beat.address = ADDR_W'($urandom_range(0, TABLE_LEN - 1));
        end else if (pick < 93) begin
            beat.action = ACT_CLEAR;
        end else begin
            beat.action = ACT_NONE;
        end
        // half the frequencies are audio-sized, either sign
        if ($urandom_range(0, 1) == 1) begin
            beat.frequency = FREQ_W'($urandom_range(0, 32'h000F_FFFF));
            if ($urandom_range(0, 1) == 1)
                beat.frequency = -beat.frequency;
        end
        return beat;
    endfunction

    initial begin
        osc_beat_t beat;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every entry, guard point included, so no tick reads a hole.
        program_oscillator(1'b0, '0, '0);
        for (int i = 0; i < TABLE_LEN; i++) begin
            beat         = '0;
            beat.action  = ACT_WRITE;
            beat.address = ADDR_W'(i);
            beat.value   = t_sample'($urandom);
            offer(beat);
        end
        settle();

        program_oscillator(1'b1, CFG_W'($urandom), UNIT_SCALE);
        foreach (DIRECTED_BEATS[r])
            offer(DIRECTED_BEATS[r]);
        settle();

        // Random phases: register extremes first, then free settings.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: program_oscillator(1'b0, '0, CFG_W'($urandom));
                1: program_oscillator(1'b0, '1, CFG_W'($urandom));
                2: program_oscillator(1'b0, CFG_W'($urandom), CFG_W'($urandom));
                3: program_oscillator(1'b1, CFG_W'($urandom), '0);
                4: program_oscillator(1'b1, CFG_W'($urandom), '1);
                5: program_oscillator(1'b1, CFG_W'($urandom),
                                      CFG_W'($urandom_range(1, 32'h0001_0000)));
                default: program_oscillator(1'($urandom), CFG_W'($urandom),
                                            CFG_W'($urandom));
            endcase
            // fill the pipeline against a long receiver hold once
            if (p == 2)
                long_hold_request = 1'b1;
            if (p == PHASE_COUNT - 1)
                calm = 1'b1;
            repeat (BEATS_PER_PHASE)
                offer(random_beat());
            settle();
        end

        if (failures == 0 && expected_samples.size() == 0)
            $display("** wavetable_oscillator_interp: PASSED **");
        else
            $display("** wavetable_oscillator_interp: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/wti_pkg.sv
rtl/core/wti_table.sv
rtl/core/wti_interp.sv
rtl/core/wavetable_oscillator_interp.sv
rtl/core/wti_check.sv
test/testbench.sv
